[hdl/vmbr_pkg.sv]
package vmbr_pkg;

	// coordinate width inside the window sweep (x + half box stays below 512)
	localparam int unsigned CW = 9;

	// configuration register indexes
	localparam logic [2:0] REG_OLD_VALUE    = 3'd0;
	localparam logic [2:0] REG_NEW_VALUE    = 3'd1;
	localparam logic [2:0] REG_BOX_WIDTH    = 3'd2;
	localparam logic [2:0] REG_BOX_HEIGHT   = 3'd3;
	localparam logic [2:0] REG_FRAME_WIDTH  = 3'd4;
	localparam logic [2:0] REG_FRAME_HEIGHT = 3'd5;

	// register reset values
	localparam logic [31:0] BLANK_WORD   = 32'hFF7F_FFFF;
	localparam logic [4:0]  BOX_RESET    = 5'd3;
	localparam logic [8:0]  FRAME_RESET  = 9'd256;

	// fetch request handed from the front end to the window sweep
	typedef struct packed {
		logic          valid;
		logic          oof;
		logic [CW-1:0] xc;
		logic [CW-1:0] yc;
		logic [CW-1:0] x0;
		logic [CW-1:0] x1;
		logic [CW-1:0] y0;
		logic [CW-1:0] y1;
	} scan_cmd_t;

	typedef enum logic [2:0] {
		SC_IDLE,
		SC_CENTRE,
		SC_SWEEP,
		SC_DRAIN,
		SC_OUT
	} scan_state_t;

	// what the word coming back from the frame memory belongs to
	typedef enum logic [1:0] {
		TAG_NONE,
		TAG_CENTRE,
		TAG_WIN
	} rd_tag_t;

endpackage

[hdl/vmbr_ram.sv]
module vmbr_ram #(
	parameter int unsigned WIDTH  = 32,
	parameter int unsigned ADDR_W = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	localparam int unsigned DEPTH = 1 << ADDR_W;

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hdl/vmbr_scan.sv]
module vmbr_scan #(
	parameter int unsigned XW = 8,
	parameter int unsigned YW = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  vmbr_pkg::scan_cmd_t  cmd,
	output logic                 idle,
	input  logic [31:0]          old_value,
	input  logic [31:0]          new_value,
	output logic                 rd_en,
	output logic [XW+YW-1:0]     rd_addr,
	input  logic [31:0]          rd_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [31:0]          pixel_out,
	output logic                 out_of_frame
);

	localparam int unsigned CW = vmbr_pkg::CW;

	vmbr_pkg::scan_state_t state_q, state_d;
	vmbr_pkg::rd_tag_t     tag_s1, tag_d;

	logic [CW-1:0] xc_q, yc_q, x0_q, x1_q, y0_q, y1_q, xx_q, yy_q;
	logic          err_q;
	logic          hit_q;
	logic [31:0]   centre_q;
	logic          out_valid_q;
	logic [31:0]   pixel_out_q;
	logic          oof_q;
	logic          out_free;
	logic          load_out;
	logic          last_x, last_y;

	assign out_free = !out_valid_q || !out_stall;
	assign last_x   = (xx_q == x1_q);
	assign last_y   = (yy_q == y1_q);
	assign idle     = (state_q == vmbr_pkg::SC_IDLE);

	// next state, read issue and output load
	always_comb begin
		state_d  = state_q;
		tag_d    = vmbr_pkg::TAG_NONE;
		rd_en    = 1'b0;
		rd_addr  = {YW'(yy_q), XW'(xx_q)};
		load_out = 1'b0;
		unique case (state_q)
			vmbr_pkg::SC_IDLE: begin
				if (cmd.valid) begin
					state_d = cmd.oof ? vmbr_pkg::SC_OUT : vmbr_pkg::SC_CENTRE;
				end
			end
			vmbr_pkg::SC_CENTRE: begin
				rd_en   = 1'b1;
				rd_addr = {YW'(yc_q), XW'(xc_q)};
				tag_d   = vmbr_pkg::TAG_CENTRE;
				state_d = vmbr_pkg::SC_SWEEP;
			end
			vmbr_pkg::SC_SWEEP: begin
				rd_en = 1'b1;
				tag_d = vmbr_pkg::TAG_WIN;
				if (last_x && last_y) begin
					state_d = vmbr_pkg::SC_DRAIN;
				end
			end
			vmbr_pkg::SC_DRAIN: begin
				state_d = vmbr_pkg::SC_OUT;
			end
			vmbr_pkg::SC_OUT: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = vmbr_pkg::SC_IDLE;
				end
			end
			default: begin
				state_d = vmbr_pkg::SC_IDLE;
			end
		endcase
	end

	// state, read tag and output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= vmbr_pkg::SC_IDLE;
			tag_s1      <= vmbr_pkg::TAG_NONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			tag_s1  <= tag_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// latch the request and walk the window row by row
	always_ff @(posedge clk) begin
		if (state_q == vmbr_pkg::SC_IDLE && cmd.valid) begin
			xc_q  <= cmd.xc;
			yc_q  <= cmd.yc;
			x0_q  <= cmd.x0;
			x1_q  <= cmd.x1;
			y0_q  <= cmd.y0;
			y1_q  <= cmd.y1;
			err_q <= cmd.oof;
		end
		if (state_q == vmbr_pkg::SC_CENTRE) begin
			xx_q <= x0_q;
			yy_q <= y0_q;
		end else if (state_q == vmbr_pkg::SC_SWEEP) begin
			if (last_x) begin
				xx_q <= x0_q;
				yy_q <= yy_q + 1'b1;
			end else begin
				xx_q <= xx_q + 1'b1;
			end
		end
	end

	// compare each returning word against the search value and keep the centre word
	always_ff @(posedge clk) begin
		if (state_q == vmbr_pkg::SC_IDLE) begin
			hit_q <= 1'b0;
		end else if (tag_s1 == vmbr_pkg::TAG_WIN && rd_data == old_value) begin
			hit_q <= 1'b1;
		end
		if (tag_s1 == vmbr_pkg::TAG_CENTRE) begin
			centre_q <= rd_data;
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (load_out) begin
			if (err_q) begin
				pixel_out_q <= '0;
				oof_q       <= 1'b1;
			end else begin
				pixel_out_q <= hit_q ? new_value : centre_q;
				oof_q       <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_out    = pixel_out_q;
	assign out_of_frame = oof_q;

endmodule

[hdl/value_match_box_replace_unit.sv]
// Box dilation with value replacement over a frame memory of 32-bit pixel words.
// A load word (req_type 0) writes pixel_in at x_pos, y_pos and gives no result; a
// load outside the frame is dropped. A fetch word (req_type 1) reads the centre
// pixel and then every pixel of the window clipped to the frame, one memory read a
// cycle through the single read port, and returns new_value if any of them equals
// old_value, else the centre pixel. A fetch takes in turn a centre read, one read
// per window pixel, a drain state for the last read to return and an output state
// that loads the output register. A fetch outside the frame skips the reads and
// returns zero with out_of_frame set. in_stall is high while a fetch is in progress
// and stays high while the output register still holds a stalled word; a finished
// word waits in the output register while the next item is taken. Pixels never
// loaded read back undefined. Registers may be written only while the block is
// idle; cfg_ready is always high.
module value_match_box_replace_unit #(
	parameter int unsigned MAX_WIDTH  = 256,
	parameter int unsigned MAX_HEIGHT = 256,
	parameter int unsigned MAX_BOX    = 31
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [7:0]  x_pos,
	input  logic [7:0]  y_pos,
	input  logic [31:0] pixel_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] pixel_out,
	output logic        out_of_frame,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int unsigned CW = vmbr_pkg::CW;
	localparam int unsigned XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int unsigned YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	logic [31:0] old_value_q, new_value_q;
	logic [4:0]  box_width_q, box_height_q;
	logic [8:0]  frame_width_q, frame_height_q;

	logic [8:0]    eff_w, eff_h;
	logic [4:0]    box_w_sat, box_h_sat;
	logic [3:0]    half_x, half_y;
	logic [CW-1:0] xin, yin, xsum, ysum, wm1, hm1;
	logic          in_bounds;
	logic          in_acc;
	logic          scan_idle;
	logic          ram_re;
	logic [XW+YW-1:0] ram_raddr;
	logic [31:0]   ram_rdata;
	vmbr_pkg::scan_cmd_t cmd;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			old_value_q    <= vmbr_pkg::BLANK_WORD;
			new_value_q    <= vmbr_pkg::BLANK_WORD;
			box_width_q    <= vmbr_pkg::BOX_RESET;
			box_height_q   <= vmbr_pkg::BOX_RESET;
			frame_width_q  <= vmbr_pkg::FRAME_RESET;
			frame_height_q <= vmbr_pkg::FRAME_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				vmbr_pkg::REG_OLD_VALUE:    old_value_q    <= cfg_data;
				vmbr_pkg::REG_NEW_VALUE:    new_value_q    <= cfg_data;
				vmbr_pkg::REG_BOX_WIDTH:    box_width_q    <= cfg_data[4:0];
				vmbr_pkg::REG_BOX_HEIGHT:   box_height_q   <= cfg_data[4:0];
				vmbr_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[8:0];
				vmbr_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data[8:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	// clamp frame and box sizes to what the store and window allow
	assign eff_w     = (32'(frame_width_q) > MAX_WIDTH) ? 9'(MAX_WIDTH) : frame_width_q;
	assign eff_h     = (32'(frame_height_q) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : frame_height_q;
	assign box_w_sat = (32'(box_width_q) > MAX_BOX) ? 5'(MAX_BOX) : box_width_q;
	assign box_h_sat = (32'(box_height_q) > MAX_BOX) ? 5'(MAX_BOX) : box_height_q;
	assign half_x    = box_w_sat[4:1];
	assign half_y    = box_h_sat[4:1];

	// window bounds, clipped to the frame
	assign xin       = CW'(x_pos);
	assign yin       = CW'(y_pos);
	assign xsum      = xin + CW'(half_x);
	assign ysum      = yin + CW'(half_y);
	assign wm1       = eff_w - 1'b1;
	assign hm1       = eff_h - 1'b1;
	assign in_bounds = (xin < eff_w) && (yin < eff_h);

	assign in_stall = !scan_idle;
	assign in_acc   = in_valid && !in_stall;

	always_comb begin
		cmd.valid = in_acc && req_type;
		cmd.oof   = !in_bounds;
		cmd.xc    = xin;
		cmd.yc    = yin;
		cmd.x0    = (xin > CW'(half_x)) ? xin - CW'(half_x) : '0;
		cmd.y0    = (yin > CW'(half_y)) ? yin - CW'(half_y) : '0;
		cmd.x1    = (xsum > wm1) ? wm1 : xsum;
		cmd.y1    = (ysum > hm1) ? hm1 : ysum;
	end

	vmbr_ram #(
		.WIDTH  (32),
		.ADDR_W (XW + YW)
	) u_frame (
		.clk   (clk),
		.we    (in_acc && !req_type && in_bounds),
		.waddr ({YW'(yin), XW'(xin)}),
		.wdata (pixel_in),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	vmbr_scan #(
		.XW (XW),
		.YW (YW)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.idle         (scan_idle),
		.old_value    (old_value_q),
		.new_value    (new_value_q),
		.rd_en        (ram_re),
		.rd_addr      (ram_raddr),
		.rd_data      (ram_rdata),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_out    (pixel_out),
		.out_of_frame (out_of_frame)
	);

endmodule

[sim/tb_value_match_box_replace_unit.sv]
module tb_value_match_box_replace_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic       REQ_LOAD     = 1'b0;
	localparam logic       REQ_FETCH    = 1'b1;
	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;
	// index slot left unused by load and fetch rows
	localparam logic [2:0] NO_REG       = vmbr_pkg::REG_OLD_VALUE;

	localparam int FRAME_MAX = 256;
	localparam int PATCH     = 8;
	localparam int WORD_GOAL = 2000;
	localparam int CALM_FROM = 1700;
	localparam int PHASE_LEN = 120;
	localparam int SETTLE    = 16;
	localparam int PLAN_LEN  = 34;

	typedef enum logic [1:0] {ROW_LOAD, ROW_FETCH, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [2:0]  idx;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [31:0] word;
		logic        typed;
		logic [31:0] want_pix;
		logic        want_oof;
	} row_t;

	typedef struct packed {
		logic [31:0] pix;
		logic        oof;
	} pixel_res_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        in_valid     = 1'b0;
	logic        req_type     = REQ_LOAD;
	logic [7:0]  x_pos        = '0;
	logic [7:0]  y_pos        = '0;
	logic [31:0] pixel_in     = '0;
	logic        out_stall    = 1'b0;
	logic        cfg_valid    = 1'b0;
	logic [2:0]  cfg_index    = vmbr_pkg::REG_OLD_VALUE;
	logic [31:0] cfg_data     = '0;
	logic        in_stall;
	logic        out_valid;
	logic [31:0] pixel_out;
	logic        out_of_frame;
	logic        cfg_ready;

	// mirror of the frame memory and of the register file
	logic [31:0] frame_mem [FRAME_MAX*FRAME_MAX];
	bit          loaded    [FRAME_MAX*FRAME_MAX];
	logic [31:0] cur_old   = vmbr_pkg::BLANK_WORD;
	logic [31:0] cur_new   = vmbr_pkg::BLANK_WORD;
	logic [4:0]  cur_box_w = vmbr_pkg::BOX_RESET;
	logic [4:0]  cur_box_h = vmbr_pkg::BOX_RESET;
	logic [8:0]  cur_fw    = vmbr_pkg::FRAME_RESET;
	logic [8:0]  cur_fh    = vmbr_pkg::FRAME_RESET;

	pixel_res_t  pending_q [$];
	pixel_res_t  head;
	row_t        dir_plan [PLAN_LEN];
	int          fail_count = 0;
	int          live_words = 0;
	int          stall_left = 0;
	bit          calm       = 1'b0;

	value_match_box_replace_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.x_pos        (x_pos),
		.y_pos        (y_pos),
		.pixel_in     (pixel_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_out    (pixel_out),
		.out_of_frame (out_of_frame),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic int clip_dim(logic [8:0] v);
		return (v > FRAME_MAX) ? FRAME_MAX : int'(v);
	endfunction

	function automatic bit in_frame(int x, int y);
		return (x < clip_dim(cur_fw)) && (y < clip_dim(cur_fh));
	endfunction

	// window around a pixel, clipped to the frame
	function automatic void window_of(input int x, input int y,
			output int x0, output int x1, output int y0, output int y1);
		int hx;
		int hy;
		hx = int'(cur_box_w) / 2;
		hy = int'(cur_box_h) / 2;
		x0 = (x > hx) ? x - hx : 0;
		y0 = (y > hy) ? y - hy : 0;
		x1 = (x + hx > clip_dim(cur_fw) - 1) ? clip_dim(cur_fw) - 1 : x + hx;
		y1 = (y + hy > clip_dim(cur_fh) - 1) ? clip_dim(cur_fh) - 1 : y + hy;
	endfunction

	// dilated pixel: new word if the old word sits anywhere in the window
	function automatic pixel_res_t dilate_pixel(int x, int y);
		pixel_res_t r;
		int x0, x1, y0, y1;
		bit hit;
		hit = 1'b0;
		r.pix = '0;
		r.oof = 1'b1;
		if (in_frame(x, y)) begin
			window_of(x, y, x0, x1, y0, y1);
			for (int yy = y0; yy <= y1; yy++)
				for (int xx = x0; xx <= x1; xx++)
					if (frame_mem[yy*FRAME_MAX + xx] == cur_old)
						hit = 1'b1;
			r.pix = hit ? cur_new : frame_mem[y*FRAME_MAX + x];
			r.oof = 1'b0;
		end
		return r;
	endfunction

	function automatic void set_reg(logic [2:0] idx, logic [31:0] d);
		case (idx)
			vmbr_pkg::REG_OLD_VALUE:    cur_old   = d;
			vmbr_pkg::REG_NEW_VALUE:    cur_new   = d;
			vmbr_pkg::REG_BOX_WIDTH:    cur_box_w = d[4:0];
			vmbr_pkg::REG_BOX_HEIGHT:   cur_box_h = d[4:0];
			vmbr_pkg::REG_FRAME_WIDTH:  cur_fw    = d[8:0];
			vmbr_pkg::REG_FRAME_HEIGHT: cur_fh    = d[8:0];
			default: ;
		endcase
	endfunction

	function automatic logic [31:0] pick_word();
		int r;
		r = $urandom_range(0, 11);
		if (r == 0)
			return cur_old;
		if (r == 1)
			return cur_new;
		return $urandom();
	endfunction

	function automatic int pick_dim();
		int d;
		case ($urandom_range(0, 9))
			0:       d = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(257, 511);
			1:       d = FRAME_MAX;
			2:       d = 1;
			3, 4, 5: d = $urandom_range(2, 16);
			default: d = $urandom_range(17, 255);
		endcase
		return d;
	endfunction

	function automatic int pick_box(bit big);
		if (big)
			return ($urandom_range(0, 2) == 0) ? 31 : $urandom_range(16, 30);
		return $urandom_range(0, 6);
	endfunction

	function automatic int patch_base(int extent);
		int b;
		if (extent <= PATCH)
			return 0;
		case ($urandom_range(0, 2))
			0:       b = 0;
			1:       b = extent - PATCH;
			default: b = $urandom_range(0, extent - PATCH);
		endcase
		return b;
	endfunction

	task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (fail_count < 100)
			$display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
		fail_count++;
	endtask

	// offer one word, idling first now and then, and log it once taken
	task automatic send_word(logic rt, logic [7:0] x, logic [7:0] y, logic [31:0] w,
			logic typed = 1'b0, pixel_res_t want = '0);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rt;
		x_pos    <= x;
		y_pos    <= y;
		pixel_in <= w;
		do @(posedge clk); while (!(in_valid && !in_stall));
		live_words++;
		if (rt == REQ_FETCH) begin
			pending_q.push_back(typed ? want : dilate_pixel(x, y));
		end else if (in_frame(x, y)) begin
			frame_mem[int'(y)*FRAME_MAX + int'(x)] = w;
			loaded[int'(y)*FRAME_MAX + int'(x)]    = 1'b1;
		end
	endtask

	// drain the block, then write one register
	task automatic write_reg(logic [2:0] idx, logic [31:0] d);
		in_valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		set_reg(idx, d);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// load every pixel of the window that has never been written
	task automatic fill_window(int x, int y);
		int x0, x1, y0, y1;
		if (!in_frame(x, y))
			return;
		window_of(x, y, x0, x1, y0, y1);
		for (int yy = y0; yy <= y1; yy++)
			for (int xx = x0; xx <= x1; xx++)
				if (!loaded[yy*FRAME_MAX + xx])
					send_word(REQ_LOAD, 8'(xx), 8'(yy), pick_word());
	endtask

	// check each result word and stall the output in random bursts
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_q.size() == 0) begin
				flag_mismatch("result with nothing pending", pixel_out, 32'd0);
			end else begin
				head = pending_q.pop_front();
				if (pixel_out !== head.pix)
					flag_mismatch("pixel_out", pixel_out, head.pix);
				if (out_of_frame !== head.oof)
					flag_mismatch("out_of_frame", 32'(out_of_frame), 32'(head.oof));
			end
		end
		if (calm || !arst_n) begin
			stall_left = 0;
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 11) == 0) begin
			stall_left = $urandom_range(1, 18) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	initial begin
		pixel_res_t want;
		logic [31:0] old_w;
		logic rt;
		bit big;
		int fw, fh, bw, bh, px, py, r, x, y, ax, ay, phase_end;

		// directed words: single-pixel windows, empty and clipped frames, ignored indexes
		dir_plan = '{
			'{ROW_CFG,   vmbr_pkg::REG_BOX_WIDTH,    8'd0, 8'd0, 32'd0, 1'b0, 32'd0, 1'b0},
			'{ROW_CFG,   vmbr_pkg::REG_BOX_HEIGHT,   8'd0, 8'd0, 32'd0, 1'b0, 32'd0, 1'b0},
			'{ROW_LOAD,  NO_REG, 8'd0,   8'd0,   32'h0,                1'b0, 32'd0, 1'b0},
			'{ROW_LOAD,  NO_REG, 8'd255, 8'd255, 32'hFFFFFFFF,         1'b0, 32'd0, 1'b0},
			'{ROW_LOAD,  NO_REG, 8'd255, 8'd0,   vmbr_pkg::BLANK_WORD, 1'b0, 32'd0, 1'b0},
			'{ROW_LOAD,  NO_REG, 8'd0,   8'd255, 32'h12345678,         1'b0, 32'd0, 1'b0},
			'{ROW_FETCH, NO_REG, 8'd0,   8'd0,   32'h0, 1'b1, 32'h0,                 1'b0},
			'{ROW_FETCH, NO_REG, 8'd255, 8'd255, 32'h0, 1'b1, 32'hFFFFFFFF,          1'b0},
			'{ROW_FETCH, NO_REG, 8'd255, 8'd0,   32'h0, 1'b1, vmbr_pkg::BLANK_WORD,  1'b0},
			'{ROW_FETCH, NO_REG, 8'd0,   8'd255, 32'h0, 1'b1, 32'h12345678,          1'b0},
			'{ROW_CFG,   vmbr_pkg::REG_NEW_VALUE, 8'd0, 8'd0, 32'hA5A5A5A5, 1'b0, 32'd0, 1'b0},
			'{ROW_FETCH, NO_REG, 8'd255, 8'd0,   32'h0, 1'b1, 32'hA5A5A5A5,          1'b0},
			'{ROW_CFG,   vmbr_pkg::REG_FRAME_WIDTH,  8'd0, 8'd0, 32'd0, 1'b0, 32'd0, 1'b0},
			'{ROW_LOAD,  NO_REG, 8'd0,   8'd0,   32'hDEADBEEF,         1'b0, 32'd0, 1'b0},
			'{ROW_FETCH, NO_REG, 8'd0,   8'd0,   32'h0, 1'b1, 32'h0,                 1'b1},
			'{ROW_FETCH, NO_REG, 8'd255, 8'd255, 32'h0, 1'b1, 32'h0,                 1'b1},
			'{ROW_CFG,   vmbr_pkg::REG_FRAME_WIDTH,  8'd0, 8'd0, 32'h1FF, 1'b0, 32'd0, 1'b0},
			'{ROW_CFG,   vmbr_pkg::REG_FRAME_HEIGHT, 8'd0, 8'd0, 32'd1, 1'b0, 32'd0, 1'b0},
			'{ROW_FETCH, NO_REG, 8'd0,   8'd255, 32'h0, 1'b1, 32'h0,                 1'b1},
			'{ROW_FETCH, NO_REG, 8'd255, 8'd0,   32'h0, 1'b1, 32'hA5A5A5A5,          1'b0},
			'{ROW_FETCH, NO_REG, 8'd0,   8'd0,   32'h0, 1'b1, 32'h0,                 1'b0},
			'{ROW_CFG,   vmbr_pkg::REG_FRAME_HEIGHT, 8'd0, 8'd0, 32'd256, 1'b0, 32'd0, 1'b0},
			'{ROW_CFG,   REG_SPARE_LO, 8'd0, 8'd0, 32'hFFFFFFFF, 1'b0, 32'd0, 1'b0},
			'{ROW_CFG,   REG_SPARE_HI, 8'd0, 8'd0, 32'hFFFFFFFF, 1'b0, 32'd0, 1'b0},
			'{ROW_FETCH, NO_REG, 8'd255, 8'd255, 32'h0, 1'b1, 32'hFFFFFFFF,          1'b0},
			'{ROW_CFG,   vmbr_pkg::REG_OLD_VALUE, 8'd0, 8'd0, 32'hFFFFFFFF, 1'b0, 32'd0, 1'b0},
			'{ROW_FETCH, NO_REG, 8'd255, 8'd255, 32'h0, 1'b1, 32'hA5A5A5A5,          1'b0},
			'{ROW_CFG,   vmbr_pkg::REG_BOX_WIDTH,    8'd0, 8'd0, 32'd2, 1'b0, 32'd0, 1'b0},
			'{ROW_CFG,   vmbr_pkg::REG_BOX_HEIGHT,   8'd0, 8'd0, 32'd2, 1'b0, 32'd0, 1'b0},
			'{ROW_LOAD,  NO_REG, 8'd254, 8'd254, 32'd1,                1'b0, 32'd0, 1'b0},
			'{ROW_LOAD,  NO_REG, 8'd255, 8'd254, 32'd3,                1'b0, 32'd0, 1'b0},
			'{ROW_LOAD,  NO_REG, 8'd254, 8'd255, 32'd2,                1'b0, 32'd0, 1'b0},
			'{ROW_CFG,   vmbr_pkg::REG_OLD_VALUE, 8'd0, 8'd0, 32'd3, 1'b0, 32'd0, 1'b0},
			'{ROW_FETCH, NO_REG, 8'd255, 8'd255, 32'h0, 1'b0, 32'd0,                 1'b0}
		};

		// hold reset, then release it on a clock edge
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_plan[i]) begin
			want.pix = dir_plan[i].want_pix;
			want.oof = dir_plan[i].want_oof;
			case (dir_plan[i].kind)
				ROW_CFG:  write_reg(dir_plan[i].idx, dir_plan[i].word);
				ROW_LOAD: send_word(REQ_LOAD, dir_plan[i].x, dir_plan[i].y, dir_plan[i].word);
				default:  send_word(REQ_FETCH, dir_plan[i].x, dir_plan[i].y, dir_plan[i].word,
						dir_plan[i].typed, want);
			endcase
		end

		// random phases: a fresh setting, then fetches and loads around a patch
		while (live_words < WORD_GOAL) begin
			big = ($urandom_range(0, 5) == 0);
			fw  = big ? $urandom_range(1, 24) : pick_dim();
			fh  = big ? $urandom_range(1, 24) : pick_dim();
			bw  = pick_box(big);
			bh  = pick_box(big);
			case ($urandom_range(0, 3))
				0:       old_w = vmbr_pkg::BLANK_WORD;
				1:       old_w = '0;
				2:       old_w = '1;
				default: old_w = $urandom();
			endcase
			write_reg(vmbr_pkg::REG_OLD_VALUE, old_w);
			write_reg(vmbr_pkg::REG_NEW_VALUE,
					($urandom_range(0, 3) == 0) ? vmbr_pkg::BLANK_WORD : $urandom());
			write_reg(vmbr_pkg::REG_BOX_WIDTH,    {27'($urandom()), 5'(bw)});
			write_reg(vmbr_pkg::REG_BOX_HEIGHT,   {27'($urandom()), 5'(bh)});
			write_reg(vmbr_pkg::REG_FRAME_WIDTH,  {23'($urandom()), 9'(fw)});
			write_reg(vmbr_pkg::REG_FRAME_HEIGHT, {23'($urandom()), 9'(fh)});
			if ($urandom_range(0, 7) == 0)
				write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_LO : REG_SPARE_HI, $urandom());

			px = patch_base(clip_dim(cur_fw));
			py = patch_base(clip_dim(cur_fh));
			phase_end = live_words + PHASE_LEN;
			while (live_words < phase_end) begin
				calm = (live_words >= CALM_FROM);
				r  = $urandom_range(0, 9);
				rt = (r <= 5) ? REQ_FETCH : REQ_LOAD;
				x  = px + $urandom_range(0, PATCH - 1);
				y  = py + $urandom_range(0, PATCH - 1);
				// anywhere on the grid; a fetch keeps it only when it falls outside the frame
				if (r == 5 || r == 9) begin
					ax = $urandom_range(0, 255);
					ay = $urandom_range(0, 255);
					if (rt == REQ_LOAD || !in_frame(ax, ay)) begin
						x = ax;
						y = ay;
					end
				end
				if (rt == REQ_FETCH)
					fill_window(x, y);
				send_word(rt, 8'(x), 8'(y), (rt == REQ_LOAD) ? pick_word() : $urandom());
			end
		end

		// drop valid, wait for the last words, then let the pipeline settle
		in_valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#80ms;
		$display("simulation failed");
		$finish;
	end

endmodule

[filelist.f]
hdl/vmbr_pkg.sv
hdl/vmbr_ram.sv
hdl/vmbr_scan.sv
hdl/value_match_box_replace_unit.sv
sim/tb_value_match_box_replace_unit.sv
